FILE: rtl/tpsd_pkg.sv
// Shared types and constants for the triangle plane signed distance block.
// Used by tpsd_unitvec and triangle_plane_signed_distance_top; depends on nothing else.
package tpsd_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // Result fields are 32 bits; the normal is Q1.30.
  localparam int OUT_W     = 32;
  localparam int NORM_W    = 32;
  localparam int NORM_FRAC = 30;

  // Scaled cross product magnitudes lie below 2^31.
  localparam int MAG_W      = 31;
  localparam int ROOT_IN_W  = 64;
  localparam int ROOT_STEPS = ROOT_IN_W / 2;
  localparam int QUO_STEPS  = MAG_W;
  localparam int REM_W      = MAG_W + NORM_FRAC + 1;

  // Division by three through a reciprocal; exact for dividends below 2^33.
  localparam int               QUO3_W      = 33;
  localparam logic [QUO3_W-1:0] RECIP3     = 33'd5726623062;
  localparam int               RECIP_SHIFT = 34;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  // Sideband that rides along the normalization: flag, three signs,
  // three vertex sums and three distance terms.
  function automatic int side_width(input int cw);
    return 4 + 3 * (cw + 2) + 3 * (cw + 3);
  endfunction

  localparam int SIDE_W_DEF = side_width(COORD_WIDTH_DEF);

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic signed [OUT_W-1:0] plane_offset;
    logic signed [OUT_W-1:0] signed_distance;
    logic                    degenerate;
  } result_t;

endpackage

FILE: rtl/triangle_plane_signed_distance_top.sv
// Triangle plane signed distance: one item per clock while in_stall is low. The
// pipeline is thirteen arithmetic stages plus the 32-step square root and the 31-step
// divider in tpsd_unitvec. A two-entry output buffer lets the pipeline keep accepting
// items while a result waits; in_stall rises only when both entries hold results.
// Degenerate triangles give a set flag and zero outputs.
// Depends on tpsd_pkg and tpsd_unitvec.
module triangle_plane_signed_distance_top #(
  parameter int COORD_WIDTH = tpsd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       a_x,
  input  logic signed [COORD_WIDTH-1:0]       a_y,
  input  logic signed [COORD_WIDTH-1:0]       a_z,
  input  logic signed [COORD_WIDTH-1:0]       b_x,
  input  logic signed [COORD_WIDTH-1:0]       b_y,
  input  logic signed [COORD_WIDTH-1:0]       b_z,
  input  logic signed [COORD_WIDTH-1:0]       c_x,
  input  logic signed [COORD_WIDTH-1:0]       c_y,
  input  logic signed [COORD_WIDTH-1:0]       c_z,
  input  logic signed [COORD_WIDTH-1:0]       query_x,
  input  logic signed [COORD_WIDTH-1:0]       query_y,
  input  logic signed [COORD_WIDTH-1:0]       query_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tpsd_pkg::OUT_W-1:0]   normal_x,
  output logic signed [tpsd_pkg::OUT_W-1:0]   normal_y,
  output logic signed [tpsd_pkg::OUT_W-1:0]   normal_z,
  output logic signed [tpsd_pkg::OUT_W-1:0]   plane_offset,
  output logic signed [tpsd_pkg::OUT_W-1:0]   signed_distance,
  output logic                                degenerate
);

  localparam int CW     = COORD_WIDTH;
  localparam int EW     = CW + 1;
  localparam int PRW    = 2 * EW;
  localparam int XW     = PRW + 1;
  localparam int MW     = PRW;
  localparam int LW     = $clog2(MW + 1);
  localparam int SW     = CW + 2;
  localparam int TW     = CW + 3;
  localparam int SIDE_W = tpsd_pkg::side_width(CW);
  localparam int MAGW   = tpsd_pkg::MAG_W;
  localparam int NW     = tpsd_pkg::NORM_W;
  localparam int OW     = tpsd_pkg::OUT_W;
  localparam int FR     = tpsd_pkg::NORM_FRAC;
  localparam int RTW    = tpsd_pkg::ROOT_IN_W;
  localparam int QW     = tpsd_pkg::QUO3_W;
  localparam int PSW    = NW + SW;
  localparam int PDW    = NW + TW;
  localparam int DW     = PDW + 2;
  localparam int AW     = DW + 1;
  localparam int W0     = AW - FR;
  localparam int WW     = (W0 > QW + 1) ? W0 : QW + 1;

  localparam logic [AW-1:0] HALF    = AW'(3) << (FR - 1);
  localparam logic [WW-1:0] SAT_POS = WW'(3) << (OW - 1);
  localparam logic [WW-1:0] SAT_NEG = SAT_POS + WW'(3);

  logic en;
  logic skid_valid;

  // The whole pipeline moves together unless the output buffer is full.
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Stage 1: edges, vertex sums and three times the query point.
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic signed [CW-1:0] vp [3];

  assign va[0] = a_x;
  assign va[1] = a_y;
  assign va[2] = a_z;
  assign vb[0] = b_x;
  assign vb[1] = b_y;
  assign vb[2] = b_z;
  assign vc[0] = c_x;
  assign vc[1] = c_y;
  assign vc[2] = c_z;
  assign vp[0] = query_x;
  assign vp[1] = query_y;
  assign vp[2] = query_z;

  logic signed [EW-1:0] e1_next [3];
  logic signed [EW-1:0] e2_next [3];
  logic signed [SW-1:0] sm_next [3];
  logic signed [SW-1:0] p3_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_next[k] = EW'(vb[k]) - EW'(va[k]);
      e2_next[k] = EW'(vc[k]) - EW'(vb[k]);
      sm_next[k] = SW'(va[k]) + SW'(vb[k]) + SW'(vc[k]);
      p3_next[k] = (SW'(vp[k]) <<< 1) + SW'(vp[k]);
    end
  end

  logic                 v1;
  logic signed [EW-1:0] s1_e1 [3];
  logic signed [EW-1:0] s1_e2 [3];
  logic signed [SW-1:0] s1_sm [3];
  logic signed [SW-1:0] s1_p3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e1 <= e1_next;
      s1_e2 <= e2_next;
      s1_sm <= sm_next;
      s1_p3 <= p3_next;
    end
  end

  // Stage 2: the six cross product terms and the distance terms 3P - (A+B+C).
  logic signed [PRW-1:0] pr_next [6];
  logic signed [TW-1:0]  tt_next [3];

  always_comb begin
    pr_next[0] = PRW'(s1_e1[1]) * PRW'(s1_e2[2]);
    pr_next[1] = PRW'(s1_e1[2]) * PRW'(s1_e2[1]);
    pr_next[2] = PRW'(s1_e1[2]) * PRW'(s1_e2[0]);
    pr_next[3] = PRW'(s1_e1[0]) * PRW'(s1_e2[2]);
    pr_next[4] = PRW'(s1_e1[0]) * PRW'(s1_e2[1]);
    pr_next[5] = PRW'(s1_e1[1]) * PRW'(s1_e2[0]);
    for (int k = 0; k < 3; k++) begin
      tt_next[k] = TW'(s1_p3[k]) - TW'(s1_sm[k]);
    end
  end

  logic                  v2;
  logic signed [PRW-1:0] s2_pr [6];
  logic signed [TW-1:0]  s2_tt [3];
  logic signed [SW-1:0]  s2_sm [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pr <= pr_next;
      s2_tt <= tt_next;
      s2_sm <= s1_sm;
    end
  end

  // Stage 3: cross product components.
  logic signed [XW-1:0] x_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x_next[k] = XW'(s2_pr[2*k]) - XW'(s2_pr[2*k+1]);
    end
  end

  logic                 v3;
  logic signed [XW-1:0] s3_x  [3];
  logic signed [TW-1:0] s3_tt [3];
  logic signed [SW-1:0] s3_sm [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x  <= x_next;
      s3_tt <= s2_tt;
      s3_sm <= s2_sm;
    end
  end

  // Stage 4: magnitudes and signs.
  logic [MW-1:0] mag_next [3];
  logic [2:0]    sgn_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sgn_next[k] = s3_x[k][XW-1];
      mag_next[k] = s3_x[k][XW-1] ? MW'(-s3_x[k]) : MW'(s3_x[k]);
    end
  end

  logic                 v4;
  logic [MW-1:0]        s4_mag [3];
  logic [2:0]           s4_sgn;
  logic signed [TW-1:0] s4_tt  [3];
  logic signed [SW-1:0] s4_sm  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mag <= mag_next;
      s4_sgn <= sgn_next;
      s4_tt  <= s3_tt;
      s4_sm  <= s3_sm;
    end
  end

  // Stage 5: length of the largest magnitude, taken from the OR of all three.
  logic [MW-1:0] orv;
  logic [LW-1:0] len;
  logic [LW-1:0] lz_next;
  logic          deg_next;

  always_comb begin
    orv = s4_mag[0] | s4_mag[1] | s4_mag[2];
    len = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) begin
        len = LW'(i + 1);
      end
    end
    lz_next  = LW'(MW) - len;
    deg_next = (orv == '0);
  end

  logic                 v5;
  logic [LW-1:0]        s5_lz;
  logic                 s5_deg;
  logic [MW-1:0]        s5_mag [3];
  logic [2:0]           s5_sgn;
  logic signed [TW-1:0] s5_tt  [3];
  logic signed [SW-1:0] s5_sm  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_lz  <= lz_next;
      s5_deg <= deg_next;
      s5_mag <= s4_mag;
      s5_sgn <= s4_sgn;
      s5_tt  <= s4_tt;
      s5_sm  <= s4_sm;
    end
  end

  // Stage 6: shift so the largest magnitude sits in [2^30, 2^31); low bits drop.
  logic [MW-1:0]        sh      [3];
  logic [2:0][MAGW-1:0] nm_next;
  logic [SIDE_W-1:0]    side_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh[k]      = s5_mag[k] << s5_lz;
      nm_next[k] = sh[k][MW-1 -: MAGW];
    end
    side_next = {s5_deg, s5_sgn, s5_sm[2], s5_sm[1], s5_sm[0],
                 s5_tt[2], s5_tt[1], s5_tt[0]};
  end

  logic                 v6;
  logic [2:0][MAGW-1:0] s6_nm;
  logic [SIDE_W-1:0]    s6_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_nm   <= nm_next;
      s6_side <= side_next;
    end
  end

  // Stage 7: squares.
  logic [2*MAGW-1:0] sqr_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqr_next[k] = (2 * MAGW)'(s6_nm[k]) * (2 * MAGW)'(s6_nm[k]);
    end
  end

  logic                 v7;
  logic [2*MAGW-1:0]    s7_sqr [3];
  logic [2:0][MAGW-1:0] s7_nm;
  logic [SIDE_W-1:0]    s7_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sqr  <= sqr_next;
      s7_nm   <= s6_nm;
      s7_side <= s6_side;
    end
  end

  // Stage 8: sum of squares.
  logic                 v8;
  logic [RTW-1:0]       s8_sq;
  logic [2:0][MAGW-1:0] s8_nm;
  logic [SIDE_W-1:0]    s8_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_sq   <= RTW'(s7_sqr[0]) + RTW'(s7_sqr[1]) + RTW'(s7_sqr[2]);
      s8_nm   <= s7_nm;
      s8_side <= s7_side;
    end
  end

  logic                 uv_valid;
  logic [2:0][MAGW-1:0] uv_q;
  logic [SIDE_W-1:0]    uv_side;

  tpsd_unitvec #(
    .SIDE_W (SIDE_W)
  ) u_unitvec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .sq        (s8_sq),
    .mag       (s8_nm),
    .side_in   (s8_side),
    .out_valid (uv_valid),
    .quo       (uv_q),
    .side_out  (uv_side)
  );

  // Stage 9: signed normal; unpack the sideband.
  logic signed [NW-1:0] nrm_next [3];
  logic signed [SW-1:0] usm      [3];
  logic signed [TW-1:0] utt      [3];
  logic [2:0]           usgn;

  always_comb begin
    usgn = uv_side[SIDE_W-2 -: 3];
    for (int k = 0; k < 3; k++) begin
      usm[k]      = uv_side[3*TW + k*SW +: SW];
      utt[k]      = uv_side[k*TW +: TW];
      nrm_next[k] = usgn[k] ? -NW'(uv_q[k]) : NW'(uv_q[k]);
    end
  end

  logic                 v9;
  logic signed [NW-1:0] s9_nrm [3];
  logic signed [SW-1:0] s9_sm  [3];
  logic signed [TW-1:0] s9_tt  [3];
  logic                 s9_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_nrm <= nrm_next;
      s9_sm  <= usm;
      s9_tt  <= utt;
      s9_deg <= uv_side[SIDE_W-1];
    end
  end

  // Stage 10: dot product terms.
  logic signed [PSW-1:0] ps_next [3];
  logic signed [PDW-1:0] pd_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ps_next[k] = PSW'(s9_nrm[k]) * PSW'(s9_sm[k]);
      pd_next[k] = PDW'(s9_nrm[k]) * PDW'(s9_tt[k]);
    end
  end

  logic                  v10;
  logic signed [PSW-1:0] s10_ps  [3];
  logic signed [PDW-1:0] s10_pd  [3];
  logic signed [NW-1:0]  s10_nrm [3];
  logic                  s10_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_ps  <= ps_next;
      s10_pd  <= pd_next;
      s10_nrm <= s9_nrm;
      s10_deg <= s9_deg;
    end
  end

  // Stage 11: dot sums; entry 0 is the offset, entry 1 the distance.
  logic                 v11;
  logic signed [DW-1:0] s11_dot [2];
  logic signed [NW-1:0] s11_nrm [3];
  logic                 s11_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      s11_dot[0] <= DW'(s10_ps[0]) + DW'(s10_ps[1]) + DW'(s10_ps[2]);
      s11_dot[1] <= DW'(s10_pd[0]) + DW'(s10_pd[1]) + DW'(s10_pd[2]);
      s11_nrm    <= s10_nrm;
      s11_deg    <= s10_deg;
    end
  end

  // Stage 12: add the rounding offset for division by 3 * 2^30, drop 30 bits, check saturation.
  logic [AW-1:0] av      [2];
  logic [WW-1:0] wv      [2];
  logic [1:0]    neg_next;
  logic [1:0]    sat_next;
  logic [QW-1:0] w_next  [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      neg_next[k] = s11_dot[k][DW-1];
      av[k]       = neg_next[k] ? -AW'(s11_dot[k]) : AW'(s11_dot[k]);
      wv[k]       = WW'((av[k] + HALF) >> FR);
      sat_next[k] = neg_next[k] ? (wv[k] >= SAT_NEG) : (wv[k] >= SAT_POS);
      w_next[k]   = wv[k][QW-1:0];
    end
  end

  logic                 v12;
  logic [1:0]           s12_neg;
  logic [1:0]           s12_sat;
  logic [QW-1:0]        s12_w   [2];
  logic signed [NW-1:0] s12_nrm [3];
  logic                 s12_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      s12_neg <= neg_next;
      s12_sat <= sat_next;
      s12_w   <= w_next;
      s12_nrm <= s11_nrm;
      s12_deg <= s11_deg;
    end
  end

  // Stage 13: divide by three through the reciprocal.
  logic                 v13;
  logic [2*QW-1:0]      s13_prod [2];
  logic [1:0]           s13_neg;
  logic [1:0]           s13_sat;
  logic signed [NW-1:0] s13_nrm  [3];
  logic                 s13_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        s13_prod[k] <= (2 * QW)'(s12_w[k]) * (2 * QW)'(tpsd_pkg::RECIP3);
      end
      s13_neg <= s12_neg;
      s13_sat <= s12_sat;
      s13_nrm <= s12_nrm;
      s13_deg <= s12_deg;
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= uv_valid;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
    end
  end

  // Final sign, saturation and the degenerate override.
  logic [OW-1:0]           q3   [2];
  logic signed [OW-1:0]    scl  [2];
  tpsd_pkg::result_t       res_next;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      q3[k] = s13_prod[k][tpsd_pkg::RECIP_SHIFT +: OW];
      if (s13_sat[k]) begin
        scl[k] = s13_neg[k] ? tpsd_pkg::OUT_MIN : tpsd_pkg::OUT_MAX;
      end else begin
        scl[k] = s13_neg[k] ? -q3[k] : q3[k];
      end
    end
    res_next.degenerate = s13_deg;
    if (s13_deg) begin
      res_next.normal_x        = '0;
      res_next.normal_y        = '0;
      res_next.normal_z        = '0;
      res_next.plane_offset    = '0;
      res_next.signed_distance = '0;
    end else begin
      res_next.normal_x        = OW'(s13_nrm[0]);
      res_next.normal_y        = OW'(s13_nrm[1]);
      res_next.normal_z        = OW'(s13_nrm[2]);
      res_next.plane_offset    = scl[0];
      res_next.signed_distance = scl[1];
    end
  end

  // Two-entry output buffer: head register plus one skid entry behind it.
  logic              head_valid;
  tpsd_pkg::result_t head;
  tpsd_pkg::result_t skid;
  logic              push;
  logic              pop;
  logic              to_skid;

  assign push    = en && v13;
  assign pop     = head_valid && !out_stall;
  assign to_skid = push && head_valid && !(pop && !skid_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!head_valid || pop) begin
        head_valid <= skid_valid || push;
      end
      if (to_skid) begin
        skid_valid <= 1'b1;
      end else if (pop) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (push) begin
        head <= res_next;
      end
    end
    if (to_skid) begin
      skid <= res_next;
    end
  end

  assign out_valid       = head_valid;
  assign normal_x        = head.normal_x;
  assign normal_y        = head.normal_y;
  assign normal_z        = head.normal_z;
  assign plane_offset    = head.plane_offset;
  assign signed_distance = head.signed_distance;
  assign degenerate      = head.degenerate;

`ifndef ASSERT_OFF
  // A degenerate item carries nothing but its flag.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0 &&
      plane_offset == 0 && signed_distance == 0)
    else $error("degenerate item with nonzero outputs");

  // The skid entry only fills behind a held head.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry valid with empty head");

  // Normal components never exceed one in Q1.30.
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824 &&
      normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824 &&
      normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
    else $error("normal component out of range");
`endif

endmodule

FILE: rtl/tpsd_unitvec.sv
// Pipelined integer square root and three parallel restoring dividers that
// turn scaled cross product magnitudes into Q1.30 normal magnitudes. Uses tpsd_pkg.
module tpsd_unitvec #(
  parameter int SIDE_W = tpsd_pkg::SIDE_W_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [tpsd_pkg::ROOT_IN_W-1:0]       sq,
  input  logic [2:0][tpsd_pkg::MAG_W-1:0]      mag,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  output logic [2:0][tpsd_pkg::MAG_W-1:0]      quo,
  output logic [SIDE_W-1:0]                    side_out
);

  localparam int RS    = tpsd_pkg::ROOT_STEPS;
  localparam int QS    = tpsd_pkg::QUO_STEPS;
  localparam int RTW   = tpsd_pkg::ROOT_IN_W;
  localparam int ROOTW = RTW / 2;
  localparam int MAGW  = tpsd_pkg::MAG_W;
  localparam int FR    = tpsd_pkg::NORM_FRAC;
  localparam int REMW  = tpsd_pkg::REM_W;

  logic [RTW-1:0]            rt_x    [RS];
  logic [RTW-1:0]            rt_r    [RS];
  logic [2:0][MAGW-1:0]      rt_mag  [RS];
  logic [SIDE_W-1:0]         rt_side [RS];
  logic                      rt_v    [RS];

  logic [2:0][REMW-1:0]      dv_rem  [QS];
  logic [2:0][MAGW-1:0]      dv_q    [QS];
  logic [ROOTW-1:0]          dv_m    [QS];
  logic [SIDE_W-1:0]         dv_side [QS];
  logic                      dv_v    [QS];

  // One bit of the root per stage.
  for (genvar i = 0; i < RS; i++) begin : g_root
    localparam logic [RTW-1:0] BIT = RTW'(1) << (RTW - 2 - 2 * i);
    logic [RTW-1:0]       x_src;
    logic [RTW-1:0]       r_src;
    logic [RTW-1:0]       trial;
    logic [2:0][MAGW-1:0] mag_src;
    logic [SIDE_W-1:0]    side_src;
    logic                 v_src;

    if (i == 0) begin : g_first
      assign x_src    = sq;
      assign r_src    = '0;
      assign mag_src  = mag;
      assign side_src = side_in;
      assign v_src    = in_valid;
    end else begin : g_next
      assign x_src    = rt_x[i-1];
      assign r_src    = rt_r[i-1];
      assign mag_src  = rt_mag[i-1];
      assign side_src = rt_side[i-1];
      assign v_src    = rt_v[i-1];
    end

    assign trial = r_src + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[i] <= 1'b0;
      end else if (en) begin
        rt_v[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_src >= trial) begin
          rt_x[i] <= x_src - trial;
          rt_r[i] <= (r_src >> 1) + BIT;
        end else begin
          rt_x[i] <= x_src;
          rt_r[i] <= r_src >> 1;
        end
        rt_mag[i]  <= mag_src;
        rt_side[i] <= side_src;
      end
    end
  end

  // One quotient bit per stage, most significant first. The dividend carries
  // half the divisor so the quotient comes out rounded.
  for (genvar j = 0; j < QS; j++) begin : g_div
    localparam int SH = QS - 1 - j;
    logic [2:0][REMW-1:0] rem_src;
    logic [2:0][MAGW-1:0] q_src;
    logic [ROOTW-1:0]     m_src;
    logic [SIDE_W-1:0]    side_src;
    logic                 v_src;
    logic [REMW-1:0]      dvs;
    logic [2:0][REMW-1:0] rem_next;
    logic [2:0][MAGW-1:0] q_next;

    if (j == 0) begin : g_first
      assign m_src    = rt_r[RS-1][ROOTW-1:0];
      assign q_src    = '0;
      assign side_src = rt_side[RS-1];
      assign v_src    = rt_v[RS-1];
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_src[k] = REMW'({rt_mag[RS-1][k], {FR{1'b0}}}) + REMW'(m_src >> 1);
        end
      end
    end else begin : g_next
      assign m_src    = dv_m[j-1];
      assign q_src    = dv_q[j-1];
      assign side_src = dv_side[j-1];
      assign v_src    = dv_v[j-1];
      assign rem_src  = dv_rem[j-1];
    end

    assign dvs = REMW'(m_src) << SH;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if (rem_src[k] >= dvs) begin
          rem_next[k] = rem_src[k] - dvs;
          q_next[k]   = q_src[k] | (MAGW'(1) << SH);
        end else begin
          rem_next[k] = rem_src[k];
          q_next[k]   = q_src[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (en) begin
        dv_v[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[j]  <= rem_next;
        dv_q[j]    <= q_next;
        dv_m[j]    <= m_src;
        dv_side[j] <= side_src;
      end
    end
  end

  assign out_valid = dv_v[QS-1];
  assign quo       = dv_q[QS-1];
  assign side_out  = dv_side[QS-1];

endmodule
